// File: rtl/wpsa_pkg.sv
package wpsa_pkg;

	localparam int COORD_BITS_DEF     = 16;
	localparam int MAX_COMPONENTS_DEF = 16;
	localparam int COMP_BITS          = 4;
	localparam int CNT_BITS           = 5;
	localparam int OFFSET_BITS        = 52;
	localparam int CFG_IDX_BITS       = 3;

	// Register indexes of the configuration channel.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_LO,
		REG_X_HI,
		REG_Y_LO,
		REG_Y_HI,
		REG_Z_LO,
		REG_Z_HI,
		REG_IN_COMPONENTS
	} cfg_reg_t;

	// Remainder of a component index by a small nonzero count, one
	// restoring step per index bit.
	function automatic logic [COMP_BITS-1:0] comp_mod(
		input logic [COMP_BITS-1:0] oc,
		input logic [CNT_BITS-1:0]  cnt
	);
		logic [CNT_BITS:0]   trial;
		logic [CNT_BITS-1:0] rem;
		rem = '0;
		for (int i = COMP_BITS - 1; i >= 0; i--) begin
			trial = {rem, oc[i]};
			if (trial >= {1'b0, cnt}) begin
				trial = trial - {1'b0, cnt};
			end
			rem = trial[CNT_BITS-1:0];
		end
		return rem[COMP_BITS-1:0];
	endfunction

endpackage

// File: rtl/wpsa_wrap.sv
// One axis of the wrap: floor modulo of (coord - lo) by the extent span,
// one remainder bit per pipeline stage, between an entry register and an output register.
module wpsa_wrap import wpsa_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] coord,
	input  logic signed [COORD_BITS-1:0] lo,
	input  logic signed [COORD_BITS-1:0] hi,
	output logic        [COORD_BITS:0]   span,
	output logic signed [COORD_BITS-1:0] src,
	output logic        [COORD_BITS-1:0] rel
);

	localparam int CB = COORD_BITS;

	logic signed [CB:0]   diff;
	logic        [CB-1:0] mag;
	logic        [CB-1:0] fix;

	logic [CB-1:0] rem_s [1:CB+1];
	logic [CB-1:0] dv_s  [1:CB];
	logic          neg_s [1:CB+1];
	logic [CB-1:0] rel_s;
	logic [CB-1:0] src_s;

	// The span is only meaningful when lo <= hi; the top level flags the rest.
	assign span = (CB+1)'({hi[CB-1], hi} - {lo[CB-1], lo} + (CB+1)'(1));
	assign diff = {coord[CB-1], coord} - {lo[CB-1], lo};
	assign mag  = diff[CB] ? CB'(-diff) : diff[CB-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[1] <= '0;
			dv_s[1]  <= mag;
			neg_s[1] <= diff[CB];
		end
	end

	for (genvar k = 1; k <= CB; k++) begin : g_step
		logic [CB:0] trial;

		always_comb begin
			trial = {rem_s[k], dv_s[k][CB-1]};
			if (trial >= span) begin
				trial = trial - span;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= trial[CB-1:0];
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k < CB) begin : g_shift
			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k+1] <= dv_s[k] << 1;
				end
			end
		end
	end

	// A negative distance with a nonzero remainder folds back from the span.
	assign fix = (neg_s[CB+1] && rem_s[CB+1] != '0)
		? CB'(span - {1'b0, rem_s[CB+1]}) : rem_s[CB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s <= fix;
			src_s <= lo + fix;
		end
	end

	assign rel = rel_s;
	assign src = src_s;

endmodule

// File: rtl/wrap_pad_source_address.sv
// Periodic padding address generator for a 3D multi-component image. Every
// input beat names one output element by signed x, y, z and a component index;
// each axis is wrapped into the configured whole extent [lo, hi] by a floor
// modulo, the component is reduced modulo the input component count, and the
// linear raster offset ((z*ny + y)*nx + x)*comps + comp of the source value
// from the extent origin is produced with the wrapped coordinates. When any
// axis has lo above hi the result beat carries extent_error in tuser and all
// other fields are zero. The block takes one beat per clock while the output
// is not stalled, and holds up to COORD_BITS + 5 beats in flight. The
// remainder pipelines resolve one remainder bit per stage and are followed by
// three multiply-add stages for the offset. Configuration writes are taken at
// any time on their own channel but are meant to happen only while no beat is
// in flight.
module wrap_pad_source_address import wpsa_pkg::*; #(
	parameter  int COORD_BITS     = COORD_BITS_DEF,
	parameter  int MAX_COMPONENTS = MAX_COMPONENTS_DEF,
	localparam int IN_W  = ((3 * COORD_BITS + COMP_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_BITS + COMP_BITS + OFFSET_BITS + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Input beats.
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// s_tdata, from bit 0: out_x, out_y, out_z, out_comp, zero fill.
	input  logic [IN_W-1:0]         s_tdata,
	// Result beats.
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// m_tdata, from bit 0: src_x, src_y, src_z, src_comp, src_offset, zero fill.
	output logic [OUT_W-1:0]        m_tdata,
	// m_tuser: extent_error.
	output logic                    m_tuser,
	// Configuration writes.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data
);

	localparam int CB   = COORD_BITS;
	localparam int LW   = CB + 2;     // wrap lane latency
	localparam int LAT  = LW + 3;     // lanes plus three multiply-add stages
	localparam int P1_W = 2 * CB;

	// Configuration registers.
	logic signed [CB-1:0]       x_lo_q, x_hi_q, y_lo_q, y_hi_q, z_lo_q, z_hi_q;
	logic        [CNT_BITS-1:0] comps_q;

	logic [CNT_BITS-1:0]  comps_eff;
	logic                 ext_err;
	logic                 en;

	logic signed [CB-1:0]  in_x, in_y, in_z;
	logic [COMP_BITS-1:0]  in_comp;

	// Lane outputs.
	logic [CB:0]          span_x, span_y, span_z;
	logic signed [CB-1:0] wsrc_x, wsrc_y, wsrc_z;
	logic [CB-1:0]        rel_x, rel_y, rel_z;

	// Stage valid bits, stage 1 first.
	logic [1:LAT] vld_s;

	// Side data riding along the lanes.
	logic [COMP_BITS-1:0] lane_comp_s [1:LW];
	logic                 lane_err_s  [1:LW];

	// Multiply-add tail.
	logic [P1_W-1:0]        p1_s1;
	logic [CB-1:0]          rx_s1;
	logic [CB-1:0]          sx_s1, sy_s1, sz_s1;
	logic [COMP_BITS-1:0]   comp_s1;
	logic                   err_s1;
	logic [OFFSET_BITS-1:0] p2_s2;
	logic [CB-1:0]          sx_s2, sy_s2, sz_s2;
	logic [COMP_BITS-1:0]   comp_s2;
	logic                   err_s2;
	logic [OUT_W-1:0]       data_s3;
	logic                   err_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q  <= '0;
			x_hi_q  <= '0;
			y_lo_q  <= '0;
			y_hi_q  <= '0;
			z_lo_q  <= '0;
			z_hi_q  <= '0;
			comps_q <= CNT_BITS'(1);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_LO:          x_lo_q  <= cfg_data;
				REG_X_HI:          x_hi_q  <= cfg_data;
				REG_Y_LO:          y_lo_q  <= cfg_data;
				REG_Y_HI:          y_hi_q  <= cfg_data;
				REG_Z_LO:          z_lo_q  <= cfg_data;
				REG_Z_HI:          z_hi_q  <= cfg_data;
				REG_IN_COMPONENTS: comps_q <= cfg_data[CNT_BITS-1:0];
				default:           ;
			endcase
		end
	end

	// A component count of zero acts as one, and the count is capped at the
	// largest supported pixel.
	always_comb begin
		comps_eff = (comps_q == '0) ? CNT_BITS'(1) : comps_q;
		if (int'(comps_eff) > MAX_COMPONENTS) begin
			comps_eff = CNT_BITS'(MAX_COMPONENTS);
		end
	end

	assign ext_err = (x_lo_q > x_hi_q) || (y_lo_q > y_hi_q) || (z_lo_q > z_hi_q);

	assign in_x    = s_tdata[0 +: CB];
	assign in_y    = s_tdata[CB +: CB];
	assign in_z    = s_tdata[2*CB +: CB];
	assign in_comp = s_tdata[3*CB +: COMP_BITS];

	// The whole pipeline moves together; it stalls only while the output
	// register holds a beat that is not taken.
	assign en       = !vld_s[LAT] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {s_tvalid, vld_s[1:LAT-1]};
		end
	end

	wpsa_wrap #(.COORD_BITS(CB)) u_wrap_x (
		.clk(clk), .en(en), .coord(in_x), .lo(x_lo_q), .hi(x_hi_q),
		.span(span_x), .src(wsrc_x), .rel(rel_x)
	);

	wpsa_wrap #(.COORD_BITS(CB)) u_wrap_y (
		.clk(clk), .en(en), .coord(in_y), .lo(y_lo_q), .hi(y_hi_q),
		.span(span_y), .src(wsrc_y), .rel(rel_y)
	);

	wpsa_wrap #(.COORD_BITS(CB)) u_wrap_z (
		.clk(clk), .en(en), .coord(in_z), .lo(z_lo_q), .hi(z_hi_q),
		.span(span_z), .src(wsrc_z), .rel(rel_z)
	);

	// Component remainder and error flag are settled on entry and delayed to
	// line up with the lane results.
	always_ff @(posedge clk) begin
		if (en) begin
			lane_comp_s[1] <= comp_mod(in_comp, comps_eff);
			lane_err_s[1]  <= ext_err;
			for (int k = 2; k <= LW; k++) begin
				lane_comp_s[k] <= lane_comp_s[k-1];
				lane_err_s[k]  <= lane_err_s[k-1];
			end
		end
	end

	// Offset: z and y first, then x, then components. The z span does not
	// enter the offset.
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= P1_W'(rel_z) * P1_W'(span_y) + P1_W'(rel_y);
			rx_s1   <= rel_x;
			sx_s1   <= wsrc_x;
			sy_s1   <= wsrc_y;
			sz_s1   <= wsrc_z;
			comp_s1 <= lane_comp_s[LW];
			err_s1  <= lane_err_s[LW];

			p2_s2   <= OFFSET_BITS'(p1_s1) * OFFSET_BITS'(span_x) + OFFSET_BITS'(rx_s1);
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			sz_s2   <= sz_s1;
			comp_s2 <= comp_s1;
			err_s2  <= err_s1;

			err_s3  <= err_s2;
			if (err_s2) begin
				data_s3 <= '0;
			end else begin
				data_s3 <= OUT_W'({p2_s2 * OFFSET_BITS'(comps_eff) + OFFSET_BITS'(comp_s2),
					comp_s2, sz_s2, sy_s2, sx_s2});
			end
		end
	end

	// The z span is not part of the offset but keeps the lane interface even.
	logic unused_span_z;
	assign unused_span_z = ^span_z;

	assign m_tvalid = vld_s[LAT];
	assign m_tdata  = data_s3;
	assign m_tuser  = err_s3 | (unused_span_z & 1'b0);

endmodule

// File: rtl/wpsa_chk.sv
module wpsa_chk import wpsa_pkg::*; #(
	parameter  int COORD_BITS = COORD_BITS_DEF,
	localparam int OUT_W = ((3 * COORD_BITS + COMP_BITS + OFFSET_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// A result beat that is not taken stays unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// An empty extent clears every other result field.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("extent error with nonzero result fields");

	// An empty output register never holds back input.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// A stalled result freezes the whole pipeline, input included.
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

bind wrap_pad_source_address wpsa_chk #(.COORD_BITS(COORD_BITS)) u_wpsa_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
